// ===== rtl/core/awrt_pkg.sv =====
// Package for the ack window retransmit tracker: widths, codes and defaults.
// No dependencies.
package awrt_pkg;
    localparam int WindowDepth = 16;
    localparam int SeqRange = 256;
    localparam int MaxRetx = 16;
    localparam logic [15:0] TimeoutReset = 16'd40;

    typedef enum logic [1:0] {
        FUNC_SEND = 2'd0,
        FUNC_ACK = 2'd1,
        FUNC_TICK = 2'd2,
        FUNC_CHECK = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        KIND_SENT = 3'd0,
        KIND_FULL = 3'd1,
        KIND_ACKED = 3'd2,
        KIND_UNKNOWN = 3'd3,
        KIND_RETX = 3'd4,
        KIND_DONE = 3'd5,
        KIND_TICK = 3'd6
    } kind_t;

    localparam logic [0:0] RegTimeout = 1'b0;

    // one stored entry as it moves along the chain
    typedef struct packed {
        logic        acked;
        logic        timed_out;
        logic [7:0]  seq;
        logic [7:0]  tag;
        logic [31:0] start;
    } entry_t;
endpackage

// ===== rtl/core/awrt_if.sv =====
// Valid/ready channel interfaces for the tracker.
// Depends on nothing.
interface awrt_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [7:0] seq_in;
    logic [7:0] frame_tag;
    modport source (output valid, func, seq_in, frame_tag, input ready);
    modport sink (input valid, func, seq_in, frame_tag, output ready);
endinterface

interface awrt_out_if #(parameter int CntW = 5);
    logic            valid;
    logic            ready;
    logic [2:0]      kind;
    logic [7:0]      seq_out;
    logic [7:0]      tag_out;
    logic [CntW-1:0] pending;
    logic            last;
    modport source (output valid, kind, seq_out, tag_out, pending, last, input ready);
    modport sink (input valid, kind, seq_out, tag_out, pending, last, output ready);
endinterface

// ===== rtl/core/ack_window_retransmit_tracker_unit.sv =====
// Top level of the ack window retransmit tracker: control, cell chain, APB.
// Depends on awrt_pkg, awrt_if and awrt_cell.
//
//  channel | dir | beat contents
//  in      | in  | func, seq_in, frame_tag
//  out     | out | kind, seq_out, tag_out, pending, last
//  apb     | in  | timeout_ticks at byte address 0
//
// Send and tick are accepted in ST_IDLE and the result beat is valid in the
// cycle after. Ack and check walk one rotation of the cell ring in ST_WALK,
// then load the final beat in ST_DONE. Retransmit beats leave during the
// rotation. A head ack that pops k entries turns the ring on by k more steps
// in ST_EMIT, so slot 0 holds the new head again.
// Reset clears the valid-related flags, count, sequence and clock; no sweep.
// A stalled output holds the beat, and the ring only while a retransmit waits.
module ack_window_retransmit_tracker_unit #(
    parameter int WINDOW_DEPTH = awrt_pkg::WindowDepth,
    parameter int SEQ_RANGE = awrt_pkg::SeqRange
) (
    input  logic        clk,
    input  logic        rst_n,
    awrt_in_if.sink     in_ch,
    awrt_out_if.source  out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int CntW = $clog2(WINDOW_DEPTH + 1);
    localparam int PosW = $clog2(WINDOW_DEPTH);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_WALK = 4'b0010,
        ST_EMIT = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t state_reg;
    logic [15:0] timeout_reg;
    logic [CntW-1:0] count_reg;
    logic [7:0] nseq_reg;
    logic [31:0] clock_reg;
    logic [PosW:0] pos_reg;          // rotation steps done
    logic [1:0] func_reg;
    logic [7:0] key_reg;
    logic found_reg, stop_reg, head_hit_reg, popping_reg;
    logic [7:0] ftag_reg;
    logic [CntW-1:0] nretx_reg, pop_reg;

    logic out_valid_reg, out_last_reg;
    logic [2:0] out_kind_reg;
    logic [7:0] out_seq_reg, out_tag_reg;
    logic [CntW-1:0] out_pend_reg;

    awrt_pkg::entry_t cq [WINDOW_DEPTH];
    awrt_pkg::entry_t head_mod;
    logic shift, out_free, in_win, age_old, emit_retx, out_load;
    logic [31:0] age;

    assign pready = 1'b1;
    assign prdata = {16'd0, timeout_reg};
    assign out_free = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = (state_reg == ST_IDLE) && out_free;

    // cell 0 is the head slot; the window position of the entry in cell 0 is pos_reg
    assign in_win = (32'(pos_reg) < 32'(count_reg));
    assign age = clock_reg - cq[0].start;
    assign age_old = age > {16'd0, timeout_reg};
    assign emit_retx = (func_reg == awrt_pkg::FUNC_CHECK) && in_win && !stop_reg
        && !cq[0].acked && (cq[0].timed_out || age_old)
        && (32'(nretx_reg) < awrt_pkg::MaxRetx);

    // a new beat enters the output register this cycle
    assign out_load = ((state_reg == ST_IDLE) && in_ch.valid && in_ch.ready
            && (in_ch.func == awrt_pkg::FUNC_SEND || in_ch.func == awrt_pkg::FUNC_TICK))
        || ((state_reg == ST_WALK) && emit_retx && out_free)
        || ((state_reg == ST_DONE) && out_free);

    always_comb
    begin
        head_mod = cq[0];
        if (func_reg == awrt_pkg::FUNC_ACK && in_win && !found_reg
            && cq[0].seq == key_reg)
            head_mod.acked = 1'b1;
        if (emit_retx)
            head_mod.timed_out = 1'b1;
        // drop the ack flag of entries popped after the head
        if (popping_reg && in_win && cq[0].acked)
            head_mod.acked = 1'b0;
    end

    assign shift = ((state_reg == ST_WALK) && (!emit_retx || out_free))
        || ((state_reg == ST_EMIT) && (pop_reg != '0));

    genvar g;
    generate
        for (g = 0; g < WINDOW_DEPTH; g++)
        begin : g_cell
            awrt_pkg::entry_t ld;
            logic lo;
            always_comb
            begin
                ld.acked = 1'b0;
                ld.timed_out = 1'b0;
                ld.seq = nseq_reg;
                ld.tag = in_ch.frame_tag;
                ld.start = clock_reg;
                lo = in_ch.valid && in_ch.ready && in_ch.func == awrt_pkg::FUNC_SEND
                    && count_reg < CntW'(WINDOW_DEPTH)
                    && count_reg[PosW-1:0] == PosW'(g);
            end
            awrt_cell u_cell (
                .clk(clk), .rst_n(rst_n), .shift(shift), .load(lo),
                .load_entry(ld),
                .from_next(g == WINDOW_DEPTH - 1 ? head_mod : cq[(g + 1) % WINDOW_DEPTH]),
                .q(cq[g])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            timeout_reg <= awrt_pkg::TimeoutReset;
        else if (psel && penable && pwrite && paddr[1:0] == {awrt_pkg::RegTimeout, 1'b0})
            timeout_reg <= pwdata[15:0];
    end

    // hold the beat until taken, drop it once taken unless a new one loads
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            nseq_reg <= '0;
            clock_reg <= '0;
            pos_reg <= '0;
            func_reg <= awrt_pkg::FUNC_SEND;
            key_reg <= 8'd0;
            ftag_reg <= 8'd0;
            found_reg <= 1'b0;
            stop_reg <= 1'b0;
            head_hit_reg <= 1'b0;
            popping_reg <= 1'b0;
            nretx_reg <= '0;
            pop_reg <= '0;
            out_kind_reg <= awrt_pkg::KIND_SENT;
            out_seq_reg <= 8'd0;
            out_tag_reg <= 8'd0;
            out_pend_reg <= '0;
            out_last_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_ch.valid && in_ch.ready)
                    begin
                        func_reg <= in_ch.func;
                        key_reg <= in_ch.seq_in;
                        pos_reg <= '0;
                        found_reg <= 1'b0;
                        stop_reg <= 1'b0;
                        head_hit_reg <= 1'b0;
                        popping_reg <= 1'b0;
                        nretx_reg <= '0;
                        pop_reg <= '0;
                        out_tag_reg <= 8'd0;
                        out_seq_reg <= 8'd0;
                        out_last_reg <= 1'b1;
                        out_pend_reg <= count_reg;
                        case (in_ch.func)
                            awrt_pkg::FUNC_SEND:
                            begin
                                out_seq_reg <= nseq_reg;
                                out_tag_reg <= in_ch.frame_tag;
                                if (count_reg < CntW'(WINDOW_DEPTH))
                                begin
                                    out_kind_reg <= awrt_pkg::KIND_SENT;
                                    count_reg <= count_reg + 1'b1;
                                    out_pend_reg <= count_reg + 1'b1;
                                    nseq_reg <= (32'(nseq_reg) == SEQ_RANGE - 1)
                                        ? 8'd0 : nseq_reg + 8'd1;
                                end
                                else
                                    out_kind_reg <= awrt_pkg::KIND_FULL;
                            end
                            awrt_pkg::FUNC_TICK:
                            begin
                                out_kind_reg <= awrt_pkg::KIND_TICK;
                                clock_reg <= clock_reg + 32'd1;
                            end
                            default:
                                state_reg <= ST_WALK;
                        endcase
                    end
                end
                ST_WALK:
                begin
                    if (emit_retx && out_free)
                    begin
                        out_kind_reg <= awrt_pkg::KIND_RETX;
                        out_seq_reg <= cq[0].seq;
                        out_tag_reg <= cq[0].tag;
                        out_pend_reg <= count_reg;
                        out_last_reg <= 1'b0;
                        nretx_reg <= nretx_reg + 1'b1;
                    end
                    if (shift)
                    begin
                        pos_reg <= pos_reg + 1'b1;
                        if (func_reg == awrt_pkg::FUNC_ACK && in_win && !found_reg
                            && cq[0].seq == key_reg)
                        begin
                            found_reg <= 1'b1;
                            ftag_reg <= cq[0].tag;
                            if (pos_reg == '0)
                            begin
                                head_hit_reg <= 1'b1;
                                popping_reg <= 1'b1;
                                pop_reg <= CntW'(1);
                            end
                        end
                        else if (popping_reg)
                        begin
                            if (in_win && cq[0].acked)
                                pop_reg <= pop_reg + 1'b1;
                            else
                                popping_reg <= 1'b0;
                        end
                        if (func_reg == awrt_pkg::FUNC_CHECK && in_win && !cq[0].acked
                            && !emit_retx)
                            stop_reg <= 1'b1;
                        if (32'(pos_reg) == WINDOW_DEPTH - 1)
                            state_reg <= head_hit_reg || (pos_reg == '0
                                && func_reg == awrt_pkg::FUNC_ACK && in_win
                                && cq[0].seq == key_reg) ? ST_EMIT : ST_DONE;
                    end
                end
                ST_EMIT:
                begin
                    // ring must rotate further to realign after popping
                    if (pop_reg != '0)
                    begin
                        count_reg <= count_reg - 1'b1;
                        pop_reg <= pop_reg - 1'b1;
                    end
                    else
                        state_reg <= ST_DONE;
                end
                default:
                begin
                    if (out_free)
                    begin
                        out_last_reg <= 1'b1;
                        out_pend_reg <= count_reg;
                        if (func_reg == awrt_pkg::FUNC_CHECK)
                        begin
                            out_kind_reg <= awrt_pkg::KIND_DONE;
                            out_seq_reg <= 8'd0;
                            out_tag_reg <= 8'd0;
                        end
                        else
                        begin
                            out_kind_reg <= found_reg ? awrt_pkg::KIND_ACKED
                                : awrt_pkg::KIND_UNKNOWN;
                            out_seq_reg <= key_reg;
                            out_tag_reg <= found_reg ? ftag_reg : 8'd0;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.kind = out_kind_reg;
    assign out_ch.seq_out = out_seq_reg;
    assign out_ch.tag_out = out_tag_reg;
    assign out_ch.pending = out_pend_reg;
    assign out_ch.last = out_last_reg;
endmodule

// ===== rtl/core/awrt_cell.sv =====
// One window slot of the rotating chain; passes its entry to the previous cell.
// Depends on awrt_pkg.
module awrt_cell (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             shift,
    input  logic             load,
    input  awrt_pkg::entry_t load_entry,
    input  awrt_pkg::entry_t from_next,
    output awrt_pkg::entry_t q
);
    awrt_pkg::entry_t ent_reg;
    logic acked_reg, tmo_reg;

    always_ff @(posedge clk)
    begin
        if (load)
            ent_reg <= load_entry;
        else if (shift)
            ent_reg <= from_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acked_reg <= 1'b0;
            tmo_reg <= 1'b0;
        end
        else if (load)
        begin
            acked_reg <= load_entry.acked;
            tmo_reg <= load_entry.timed_out;
        end
        else if (shift)
        begin
            acked_reg <= from_next.acked;
            tmo_reg <= from_next.timed_out;
        end
    end

    always_comb
    begin
        q = ent_reg;
        q.acked = acked_reg;
        q.timed_out = tmo_reg;
    end
endmodule

// ===== rtl/core/awrt_checker.sv =====
// Port-level checks for the tracker, bound to the top level.
// Depends on ack_window_retransmit_tracker_unit, the target of its bind.
module awrt_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic [4:0] out_pending,
    input logic pready
);
    a_ready: assert property (@(posedge clk) pready) else $error("pready low");
    a_pend: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_pending <= 5'd16) else $error("pending range");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid) else $error("beat dropped");
    a_block: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready) else $error("input open while stalled");
    a_seq: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid || !in_ready) else $error("input not closed");
endmodule

bind ack_window_retransmit_tracker_unit awrt_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_pending(out_ch.pending), .pready(pready)
);
